FILE: src/ntpm_pkg.sv
package ntpm_pkg;

    localparam int PAGE_COUNT_DEF = 135;
    localparam int PAGE_W         = 8;
    localparam int WORD_W         = 32;
    localparam int OP_W           = 3;

    localparam logic [OP_W-1:0] OP_VERSION = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
    localparam logic [OP_W-1:0] OP_AUTH    = 3'd3;

    localparam logic [PAGE_W-1:0] PG_CFG0 = 8'h83;
    localparam logic [PAGE_W-1:0] PG_CFG1 = 8'h84;
    localparam logic [PAGE_W-1:0] PG_PWD  = 8'h85;
    localparam logic [PAGE_W-1:0] PG_PACK = 8'h86;

    localparam logic [7:0] ACC_PROT  = 8'h80;
    localparam logic [7:0] ACC_LIMIT = 8'h07;
    localparam logic [7:0] FAIL_MAX  = 8'hFF;

    localparam logic [WORD_W-1:0] VERSION_WORD0 = 32'h0004_0402;
    localparam logic [WORD_W-1:0] VERSION_WORD1 = 32'h0100_1103;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_NAK = 1'b1;

    // shadow copies of the configuration pages
    typedef struct packed {
        logic [7:0]        auth0;
        logic [7:0]        access;
        logic [WORD_W-1:0] pwd;
        logic [15:0]       pack;
    } cfg_t;

    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

    function automatic logic [WORD_W-1:0] init_word(input logic [PAGE_W-1:0] addr);
        logic [WORD_W-1:0] w;
        case (addr)
            8'h00:   w = 32'h04E1_412C;
            8'h01:   w = 32'h124C_2880;
            8'h02:   w = 32'hF648_0000;
            8'h03:   w = 32'hE110_3E00;
            8'h04:   w = 32'h0300_FE00;
            PG_CFG0: w = 32'h0400_00FF;
            PG_CFG1: w = 32'h0005_0000;
            PG_PWD:  w = 32'hFFFF_FFFF;
            PG_PACK: w = 32'h0000_0000;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

FILE: src/nfc_tag_page_memory.sv
// Command engine of a password-protected tag page memory. After reset the block
// loads the delivery contents into its page RAM, one page per cycle, across all
// PAGE_COUNT pages; s_axis_tready stays low until that sweep is done. It then
// takes one command at a time: a beat is accepted, a decode state handles it, and
// results leave through a single output register at one beat per cycle while
// m_axis_tready is high. Get version returns 2 beats; read returns 4 beats, one
// page per cycle from the single RAM read port while m_axis_tready is high;
// write, password auth, unknown commands and every nak return 1 beat.
// Read wraps past the last page; password and pack pages read as zero.
module nfc_tag_page_memory
    import ntpm_pkg::*;
    #(
        parameter int PAGE_COUNT = PAGE_COUNT_DEF
    )
    (
        input  logic        aclk,
        input  logic        aresetn,
        input  logic        s_axis_tvalid,
        output logic        s_axis_tready,
        input  logic [39:0] s_axis_tdata,  // page[7:0], payload[39:8]
        input  logic [2:0]  s_axis_tuser,  // op[2:0]
        output logic        m_axis_tvalid,
        input  logic        m_axis_tready,
        output logic [31:0] m_axis_tdata,  // word[31:0]
        output logic [0:0]  m_axis_tuser,  // status[0]
        output logic        m_axis_tlast
    );

    localparam int ADDR_W = $clog2(PAGE_COUNT);
    localparam logic [PAGE_W:0] PAGE_END = (PAGE_W+1)'(PAGE_COUNT);

    logic [PAGE_W:0]   init_cnt_reg, init_cnt_next;
    logic              init_done;
    cfg_t              cfg_reg, cfg_next;
    mem_req_t          ctrl_req;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;

    assign init_done     = (init_cnt_reg == PAGE_END);
    assign init_cnt_next = init_done ? init_cnt_reg : init_cnt_reg + 1'b1;

    always_comb begin
        if (!init_done) begin
            wr_en   = 1'b1;
            wr_addr = init_cnt_reg[PAGE_W-1:0];
            wr_data = init_word(init_cnt_reg[PAGE_W-1:0]);
        end else begin
            wr_en   = ctrl_req.wr_en;
            wr_addr = ctrl_req.wr_addr;
            wr_data = ctrl_req.wr_data;
        end
    end

    // track every write to the configuration pages
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_addr)
                PG_CFG0: cfg_next.auth0  = wr_data[7:0];
                PG_CFG1: cfg_next.access = wr_data[31:24];
                PG_PWD:  cfg_next.pwd    = wr_data;
                PG_PACK: cfg_next.pack   = wr_data[31:16];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_cnt_reg <= '0;
        end else begin
            init_cnt_reg <= init_cnt_next;
        end
        cfg_reg <= cfg_next;
    end

    ntpm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PAGE_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (ctrl_req.rd_en),
        .rd_addr (ctrl_req.rd_addr[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    ntpm_ctrl #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .cfg       (cfg_reg),
        .mem_req   (ctrl_req),
        .mem_rdata (rd_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_op      (s_axis_tuser),
        .s_page    (s_axis_tdata[7:0]),
        .s_payload (s_axis_tdata[39:8]),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_status  (m_axis_tuser[0]),
        .m_word    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

endmodule

FILE: src/ntpm_ram.sv
module ntpm_ram
    #(
        parameter int WIDTH = 32,
        parameter int DEPTH = 135
    )
    (
        input  logic                     aclk,
        input  logic                     wr_en,
        input  logic [$clog2(DEPTH)-1:0] wr_addr,
        input  logic [WIDTH-1:0]         wr_data,
        input  logic                     rd_en,
        input  logic [$clog2(DEPTH)-1:0] rd_addr,
        output logic [WIDTH-1:0]         rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ntpm_ctrl.sv
module ntpm_ctrl
    import ntpm_pkg::*;
    #(
        parameter int PAGE_COUNT = PAGE_COUNT_DEF
    )
    (
        input  logic              aclk,
        input  logic              aresetn,
        input  logic              init_done,
        input  cfg_t              cfg,
        output mem_req_t          mem_req,
        input  logic [WORD_W-1:0] mem_rdata,
        input  logic              s_valid,
        output logic              s_ready,
        input  logic [OP_W-1:0]   s_op,
        input  logic [PAGE_W-1:0] s_page,
        input  logic [WORD_W-1:0] s_payload,
        output logic              m_valid,
        input  logic              m_ready,
        output logic              m_status,
        output logic [WORD_W-1:0] m_word,
        output logic              m_last
    );

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_VER   = 2'd2;
    localparam logic [1:0] ST_RDATA = 2'd3;

    localparam logic [PAGE_W:0]   PAGE_END  = (PAGE_W+1)'(PAGE_COUNT);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

    logic [1:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [WORD_W-1:0] payload_reg, payload_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [PAGE_W-1:0] addr_reg, addr_next;
    logic              session_reg, session_next;
    logic [7:0]        fail_reg, fail_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic [WORD_W-1:0] m_word_reg, m_word_next;
    logic              m_last_reg, m_last_next;

    logic              out_free;
    logic              emit;
    logic              emit_status;
    logic [WORD_W-1:0] emit_word;
    logic              emit_last;
    logic              out_of_range;
    logic              gated;
    logic [2:0]        limit;
    logic              lockout;
    logic [PAGE_W-1:0] addr_inc;

    assign out_free     = !m_valid_reg || m_ready;
    assign out_of_range = {1'b0, page_reg} >= PAGE_END;
    assign gated        = (page_reg >= cfg.auth0) && !session_reg;
    assign limit        = cfg.access[2:0] & ACC_LIMIT[2:0];
    assign lockout      = (limit != 3'd0) && (fail_reg >= {5'd0, limit});
    assign addr_inc     = (addr_reg == PAGE_LAST) ? '0 : addr_reg + 1'b1;

    assign s_ready = (state_reg == ST_IDLE) && init_done;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        page_next    = page_reg;
        payload_next = payload_reg;
        cnt_next     = cnt_reg;
        addr_next    = addr_reg;
        session_next = session_reg;
        fail_next    = fail_reg;
        emit         = 1'b0;
        emit_status  = STATUS_OK;
        emit_word    = '0;
        emit_last    = 1'b1;
        mem_req      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next      = s_op;
                    page_next    = s_page;
                    payload_next = s_payload;
                    cnt_next     = '0;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_VERSION) begin
                    state_next = ST_VER;
                end else if (op_reg == OP_READ && !out_of_range &&
                             !((cfg.access & ACC_PROT) != 8'd0 && gated)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = page_reg;
                    addr_next       = page_reg;
                    state_next      = ST_RDATA;
                end else if (out_free) begin
                    emit        = 1'b1;
                    emit_status = STATUS_NAK;
                    state_next  = ST_IDLE;
                    case (op_reg)
                        OP_WRITE: begin
                            if (!out_of_range && !gated) begin
                                emit_status     = STATUS_OK;
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = page_reg;
                                mem_req.wr_data = payload_reg;
                            end
                        end
                        OP_AUTH: begin
                            if (!lockout) begin
                                if (payload_reg != cfg.pwd) begin
                                    if (fail_reg != FAIL_MAX) begin
                                        fail_next = fail_reg + 1'b1;
                                    end
                                end else begin
                                    emit_status  = STATUS_OK;
                                    emit_word    = {16'd0, cfg.pack};
                                    fail_next    = '0;
                                    session_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_VER: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_word = cnt_reg[0] ? VERSION_WORD1 : VERSION_WORD0;
                    emit_last = cnt_reg[0];
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg[0]) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RDATA: begin
                // rd_data holds while no new read is issued
                if (out_free) begin
                    emit      = 1'b1;
                    emit_word = (addr_reg == PG_PWD || addr_reg == PG_PACK) ? '0 : mem_rdata;
                    emit_last = (cnt_reg == 2'd3);
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = addr_inc;
                        addr_next       = addr_inc;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_word_next   = m_word_reg;
        m_last_next   = m_last_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            m_status_next = emit_status;
            m_word_next   = emit_word;
            m_last_next   = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            session_reg <= 1'b0;
            fail_reg    <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            session_reg <= session_next;
            fail_reg    <= fail_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        op_reg       <= op_next;
        page_reg     <= page_next;
        payload_reg  <= payload_next;
        addr_reg     <= addr_next;
        m_status_reg <= m_status_next;
        m_word_reg   <= m_word_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_word   = m_word_reg;
    assign m_last   = m_last_reg;

endmodule

FILE: tb/sv/nfc_tag_page_memory_checker.sv
module nfc_tag_page_memory_checker
    import ntpm_pkg::*;
    #(
        parameter int PAGE_COUNT = PAGE_COUNT_DEF
    )
    (
        input  logic        aclk,
        input  logic        aresetn,
        input  logic        s_axis_tvalid,
        input  logic        s_axis_tready,
        input  logic [39:0] s_axis_tdata,  // page[7:0], payload[39:8]
        input  logic [2:0]  s_axis_tuser,  // op[2:0]
        input  logic        m_axis_tvalid,
        input  logic        m_axis_tready,
        input  logic [31:0] m_axis_tdata,  // word[31:0]
        input  logic [0:0]  m_axis_tuser,  // status[0]
        input  logic        m_axis_tlast,
        output int          fail_count,
        output int          pending_count,
        output int          cmd_count,
        output int          beat_count
    );

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] word;
        logic              last;
    } tag_reply_t;

    tag_reply_t        reply_q[$];
    logic [WORD_W-1:0] tag_pages [PAGE_COUNT];
    logic              session_open;
    logic [7:0]        bad_auths;
    int                errs = 0;
    int                cmds = 0;
    int                beats = 0;

    task automatic load_delivery_pages();
        for (int i = 0; i < PAGE_COUNT; i++) begin
            tag_pages[i] = '0;
        end
        tag_pages[0]       = 32'h04E1_412C;
        tag_pages[1]       = 32'h124C_2880;
        tag_pages[2]       = 32'hF648_0000;
        tag_pages[3]       = 32'hE110_3E00;
        tag_pages[4]       = 32'h0300_FE00;
        tag_pages[PG_CFG0] = 32'h0400_00FF;
        tag_pages[PG_CFG1] = 32'h0005_0000;
        tag_pages[PG_PWD]  = 32'hFFFF_FFFF;
        tag_pages[PG_PACK] = 32'h0000_0000;
        session_open       = 1'b0;
        bad_auths          = '0;
    endtask

    task automatic push_reply(input logic status, input logic [WORD_W-1:0] word,
                              input logic last);
        tag_reply_t r;
        r.status = status;
        r.word   = word;
        r.last   = last;
        reply_q.push_back(r);
    endtask

    task automatic predict_tag_reply(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
                                     input logic [WORD_W-1:0] data);
        logic              gated;
        logic [7:0]        access;
        logic [7:0]        limit;
        int                p;
        logic [WORD_W-1:0] w;
        gated  = pg >= tag_pages[PG_CFG0][7:0];
        access = tag_pages[PG_CFG1][31:24];
        limit  = access & ACC_LIMIT;
        case (op)
            OP_VERSION: begin
                push_reply(STATUS_OK, VERSION_WORD0, 1'b0);
                push_reply(STATUS_OK, VERSION_WORD1, 1'b1);
            end
            OP_READ: begin
                if (pg >= PAGE_COUNT) begin
                    push_reply(STATUS_NAK, '0, 1'b1);
                end else if ((access & ACC_PROT) != 0 && gated && !session_open) begin
                    push_reply(STATUS_NAK, '0, 1'b1);
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        p = (pg + i) % PAGE_COUNT;
                        w = (p == PG_PWD || p == PG_PACK) ? '0 : tag_pages[p];
                        push_reply(STATUS_OK, w, i == 3);
                    end
                end
            end
            OP_WRITE: begin
                if (pg >= PAGE_COUNT || (gated && !session_open)) begin
                    push_reply(STATUS_NAK, '0, 1'b1);
                end else begin
                    tag_pages[pg] = data;
                    push_reply(STATUS_OK, '0, 1'b1);
                end
            end
            OP_AUTH: begin
                if (limit != 0 && bad_auths >= limit) begin
                    push_reply(STATUS_NAK, '0, 1'b1);
                end else if (data != tag_pages[PG_PWD]) begin
                    if (bad_auths != FAIL_MAX) begin
                        bad_auths = bad_auths + 8'd1;
                    end
                    push_reply(STATUS_NAK, '0, 1'b1);
                end else begin
                    bad_auths    = '0;
                    session_open = 1'b1;
                    push_reply(STATUS_OK, {16'h0000, tag_pages[PG_PACK][31:16]}, 1'b1);
                end
            end
            default: begin
                push_reply(STATUS_NAK, '0, 1'b1);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        tag_reply_t want;
        if (!aresetn) begin
            load_delivery_pages();
            reply_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats++;
                if (reply_q.size() == 0) begin
                    $error("unexpected result beat: word %h status %0d",
                           m_axis_tdata, m_axis_tuser[0]);
                    errs++;
                end else begin
                    want = reply_q.pop_front();
                    if (m_axis_tuser[0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser[0]);
                        errs++;
                    end
                    if (m_axis_tdata !== want.word) begin
                        $error("word: expected %h, got %h", want.word, m_axis_tdata);
                        errs++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cmds++;
                predict_tag_reply(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]);
            end
        end
        fail_count    <= errs;
        pending_count <= reply_q.size();
        cmd_count     <= cmds;
        beat_count    <= beats;
    end

endmodule

FILE: tb/sv/nfc_tag_page_memory_tb.sv
module nfc_tag_page_memory_tb;
    import ntpm_pkg::*;

    localparam int              PAGE_COUNT   = PAGE_COUNT_DEF;
    localparam logic [OP_W-1:0] OP_UNKNOWN   = 3'd4;
    localparam logic [OP_W-1:0] OP_TOP_CODE  = 3'd7;
    localparam int              RANDOM_CMDS  = 60;
    localparam int              MISS_TRIES   = 8;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              DRAIN_LIMIT  = 10000;
    localparam int              RUN_LIMIT    = 1_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // page[7:0], payload[39:8]
    logic [2:0]  s_axis_tuser = '0;  // op[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // word[31:0]
    logic [0:0]  m_axis_tuser;       // status[0]
    logic        m_axis_tlast;

    int   fail_count;
    int   pending_count;
    int   cmd_count;
    int   beat_count;
    int   burst_left = 0;
    logic stall_req = 1'b0;
    logic hold_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nfc_tag_page_memory #(.PAGE_COUNT(PAGE_COUNT)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    nfc_tag_page_memory_checker #(.PAGE_COUNT(PAGE_COUNT)) reply_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .cmd_count     (cmd_count),
        .beat_count    (beat_count)
    );

    // Offer one command beat and hold it until accepted; open a new burst when the
    // current one is used up, usually after a gap.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
                            input logic [WORD_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, pg};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Receiver: switch between stall patterns, with one long hold-off on request.
    initial begin
        int mode;
        int mode_left;
        int cycle;
        mode_left = 0;
        cycle     = 0;
        mode      = 0;
        forever begin
            if (stall_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            cycle++;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= (cycle % 4 == 0);
            endcase
            @(posedge aclk);
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [WORD_W-1:0] cur_pwd;
        logic [WORD_W-1:0] data;
        logic [PAGE_W-1:0] pg;
        logic [OP_W-1:0]   op;
        int                pick;
        int                n;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // delivery state: no protection, no limit, default password
        send_cmd(OP_VERSION, 8'h00, 32'h0);
        send_cmd(OP_READ, 8'h00, 32'h0);
        send_cmd(OP_READ, PG_CFG1, 32'h0);
        send_cmd(OP_READ, PAGE_W'(PAGE_COUNT - 1), 32'h0);
        send_cmd(OP_READ, PAGE_W'(PAGE_COUNT), 32'h0);
        send_cmd(OP_READ, 8'hFF, 32'h0);
        send_cmd(OP_WRITE, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(OP_WRITE, 8'h05, 32'hA5A5_5A5A);
        // turn on read protection from page 10h, allow two failed auths
        send_cmd(OP_WRITE, PG_CFG1, 32'h8200_0000);
        send_cmd(OP_WRITE, PG_CFG0, 32'h0400_0010);
        send_cmd(OP_READ, 8'h10, 32'h0);
        send_cmd(OP_READ, 8'h0F, 32'h0);
        send_cmd(OP_WRITE, 8'h20, 32'h1234_5678);
        send_cmd(OP_WRITE, PG_PWD, 32'h0);
        send_cmd(OP_AUTH, 8'h00, 32'h0);
        send_cmd(OP_AUTH, 8'h00, 32'hFFFF_FFFF);
        send_cmd(OP_READ, 8'h10, 32'h0);
        send_cmd(OP_WRITE, PG_PACK, 32'hBEEF_1234);
        cur_pwd = 32'h1357_2468;
        send_cmd(OP_WRITE, PG_PWD, cur_pwd);
        // two misses reach the limit, then even the right password is refused
        send_cmd(OP_AUTH, 8'h00, ~cur_pwd);
        send_cmd(OP_AUTH, 8'h00, 32'h0);
        send_cmd(OP_AUTH, 8'h00, cur_pwd);
        send_cmd(OP_UNKNOWN, 8'h00, 32'h0);
        send_cmd(OP_TOP_CODE, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(OP_WRITE, PG_CFG1, 32'h0000_0000);
        send_cmd(OP_AUTH, 8'h00, cur_pwd);

        // pile up misses past the highest limit, then reveal the count through it
        repeat (MISS_TRIES) send_cmd(OP_AUTH, PAGE_W'($urandom), ~cur_pwd);
        send_cmd(OP_WRITE, PG_CFG1, 32'h0700_0000);
        send_cmd(OP_AUTH, 8'h00, cur_pwd);
        send_cmd(OP_WRITE, PG_CFG1, 32'h0000_0000);
        send_cmd(OP_AUTH, 8'h00, cur_pwd);

        stall_req <= 1'b1;
        repeat (RANDOM_CMDS) begin
            pick = $urandom_range(0, 99);
            pg   = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            if ($urandom_range(0, 9) == 0) begin
                pg = PAGE_W'($urandom_range(PAGE_COUNT, 255));
            end
            data = $urandom;
            if (pick < 10) begin
                op = OP_VERSION;
            end else if (pick < 45) begin
                op = OP_READ;
            end else if (pick < 78) begin
                op = OP_WRITE;
                if ($urandom_range(0, 9) == 0) begin
                    pg = PG_CFG0 + PAGE_W'($urandom_range(0, 3));
                end
            end else if (pick < 90) begin
                op = OP_AUTH;
                if ($urandom_range(0, 1) == 1) begin
                    data = cur_pwd;
                end
            end else begin
                op = OP_W'($urandom_range(OP_UNKNOWN, OP_TOP_CODE));
            end
            // session is open by now, so a password write always lands
            if (op == OP_WRITE && pg == PG_PWD) begin
                cur_pwd = data;
            end
            send_cmd(op, pg, data);
        end
        s_axis_tvalid <= 1'b0;

        n = 0;
        while (pending_count != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (20) @(posedge aclk);

        if (pending_count != 0) begin
            $error("%0d expected result beats never arrived", pending_count);
        end
        $display("Sent %0d commands (version, read, write, auth, unknown) and checked %0d beats",
                 cmd_count, beat_count);
        $display("Covered range naks, read protection, write lock, auth lockout and a long stall");
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: nfc_tag_page_memory.f
src/ntpm_pkg.sv
src/ntpm_ram.sv
src/ntpm_ctrl.sv
src/nfc_tag_page_memory.sv
tb/sv/nfc_tag_page_memory_checker.sv
tb/sv/nfc_tag_page_memory_tb.sv
